// File: design/mfb_pkg.sv
// Shared types and constants of the monochrome page framebuffer.
package mfb_pkg;

  // Input word command codes
  typedef enum logic [1:0] {
    CMD_SET_PIXEL = 2'd0,
    CMD_CLEAR_ALL = 2'd1,
    CMD_FILL_ALL  = 2'd2,
    CMD_REFRESH   = 2'd3
  } cmd_e;

  // Refresh stream: four command bytes lead each page
  parameter int unsigned CMD_SLOTS = 4;

  parameter logic [7:0] SEQ_START_LINE = 8'h40;
  parameter logic [7:0] SEQ_PAGE_BASE  = 8'hB0;
  parameter logic [7:0] SEQ_COL_HI     = 8'h10;
  parameter logic [7:0] SEQ_COL_LO     = 8'h00;
  parameter logic [7:0] BYTE_ALL_ON    = 8'hFF;
  parameter logic [7:0] BYTE_ALL_OFF   = 8'h00;

  // Controller to datapath commands
  typedef struct packed {
    logic rd_en;        // read buffer byte this cycle
    logic rd_pix;       // read address from pixel ports, else refresh position
    logic pix_wr;       // write back modified pixel byte
    logic sweep_start;  // arm a clear or fill sweep
    logic sweep_fill;   // sweep value is all-on
    logic sweep_wr;     // write one sweep byte
    logic out_load;     // load output register and advance refresh position
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic pix_ok;       // pixel ports lie on the panel
    logic sweep_last;   // sweep at last byte
    logic out_free;     // output register can take a word
  } sts_t;

endpackage

// File: design/mono_lcd_page_framebuffer_unit.sv
// Top level of the page-organised monochrome panel framebuffer.
//
// The buffer holds PANEL_PAGES pages of PANEL_WIDTH column bytes in one single-port RAM,
// bit n of a byte being row page*8+n; set-pixel words mirror the column. Handling per input
// word: a set-pixel word on the panel reads its byte and then writes it back over the one
// RAM port; one off the panel is taken and dropped; a refresh word reads the RAM and then
// loads the output register, waiting while the output register stays full; clear and fill
// write every byte of the buffer, one RAM write per byte. After reset a clearing pass over
// all PANEL_WIDTH*PANEL_PAGES bytes (1024 at 128x64) runs before the first word is taken.
// A refresh result may wait in the output register while further words are taken.
module mono_lcd_page_framebuffer_unit #(
  parameter int unsigned PANEL_WIDTH = 128,
  parameter int unsigned PANEL_PAGES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic       pixel_on_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_data_o,
  output logic       frame_last_o
);

  mfb_pkg::ctl_t ctl;
  mfb_pkg::sts_t sts;

  mfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  mfb_dp #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_PAGES (PANEL_PAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pixel_on_i   (pixel_on_i),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .is_data_o    (is_data_o),
    .frame_last_o (frame_last_o)
  );

endmodule

// File: design/mfb_ram.sv
// Generic single-port RAM with registered read.
module mfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mfb_ctrl.sv
// Controller state machine of the page framebuffer.
module mfb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    command_i,
  input  mfb_pkg::sts_t sts_i,
  output mfb_pkg::ctl_t ctl_o
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_PIX_WR,
    S_REF_OUT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mfb_pkg::cmd_e'(command_i))
            mfb_pkg::CMD_SET_PIXEL: begin
              if (sts_i.pix_ok) begin
                ctl_o.rd_en  = 1'b1;
                ctl_o.rd_pix = 1'b1;
                state_d      = S_PIX_WR;
              end
            end
            mfb_pkg::CMD_CLEAR_ALL: begin
              ctl_o.sweep_start = 1'b1;
              state_d           = S_SWEEP;
            end
            mfb_pkg::CMD_FILL_ALL: begin
              ctl_o.sweep_start = 1'b1;
              ctl_o.sweep_fill  = 1'b1;
              state_d           = S_SWEEP;
            end
            default: begin
              ctl_o.rd_en = 1'b1;
              state_d     = S_REF_OUT;
            end
          endcase
        end
      end
      S_PIX_WR: begin
        ctl_o.pix_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_SWEEP: begin
        ctl_o.sweep_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_REF_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/mfb_dp.sv
// Datapath of the page framebuffer: buffer RAM, refresh position, output register.
module mfb_dp #(
  parameter int unsigned PANEL_WIDTH = 128,
  parameter int unsigned PANEL_PAGES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    pos_x_i,
  input  logic [7:0]    pos_y_i,
  input  logic          pixel_on_i,
  input  mfb_pkg::ctl_t ctl_i,
  output mfb_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          is_data_o,
  output logic          frame_last_o
);

  localparam int unsigned DEPTH = PANEL_WIDTH * PANEL_PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned AX    = AW + 1;
  localparam int unsigned PGW   = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
  localparam int unsigned SLOTS = mfb_pkg::CMD_SLOTS + PANEL_WIDTH;
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned ROWS  = PANEL_PAGES * 8;

  // Pixel address from the input ports (mirrored column)
  logic [7:0]    pix_col;
  logic [AX-1:0] pix_sum;
  logic [AW-1:0] pix_addr;
  logic [7:0]    pix_mask;

  assign sts_o.pix_ok = ({1'b0, pos_x_i} < 9'(PANEL_WIDTH)) &&
                        ({1'b0, pos_y_i} < 9'(ROWS));
  assign pix_col  = 8'(PANEL_WIDTH - 1) - pos_x_i;
  assign pix_sum  = AX'(pos_y_i[6:3]) * AX'(PANEL_WIDTH) + AX'(pix_col);
  assign pix_addr = pix_sum[AW-1:0];
  assign pix_mask = 8'd1 << pos_y_i[2:0];

  // Latched pixel write
  logic [AW-1:0] pix_addr_q;
  logic [7:0]    pix_mask_q;
  logic          pix_on_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en && ctl_i.rd_pix) begin
      pix_addr_q <= pix_addr;
      pix_mask_q <= pix_mask;
      pix_on_q   <= pixel_on_i;
    end
  end

  // Refresh position
  logic [PGW-1:0] page_q;
  logic [SW-1:0]  slot_q;
  logic           slot_end;
  logic           page_end;
  logic           slot_data;
  logic [SW-1:0]  data_col;
  logic [AX-1:0]  ref_sum;
  logic [AW-1:0]  ref_addr;

  assign slot_end  = (slot_q == SW'(SLOTS - 1));
  assign page_end  = (page_q == PGW'(PANEL_PAGES - 1));
  assign slot_data = (slot_q >= SW'(mfb_pkg::CMD_SLOTS));
  assign data_col  = slot_data ? (slot_q - SW'(mfb_pkg::CMD_SLOTS)) : '0;
  assign ref_sum   = AX'(page_q) * AX'(PANEL_WIDTH) + AX'(data_col);
  assign ref_addr  = ref_sum[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      slot_q <= '0;
    end else if (ctl_i.out_load) begin
      if (slot_end) begin
        slot_q <= '0;
        page_q <= page_end ? '0 : page_q + PGW'(1);
      end else begin
        slot_q <= slot_q + SW'(1);
      end
    end
  end

  // Clear / fill sweep counter; reset arms a clearing pass
  logic [AW-1:0] sweep_q;
  logic          fill_q;

  assign sts_o.sweep_last = (sweep_q == AW'(DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      fill_q  <= 1'b0;
    end else if (ctl_i.sweep_start) begin
      sweep_q <= '0;
      fill_q  <= ctl_i.sweep_fill;
    end else if (ctl_i.sweep_wr) begin
      sweep_q <= sts_o.sweep_last ? '0 : sweep_q + AW'(1);
    end
  end

  // Buffer RAM port selection
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic          ram_we;

  always_comb begin
    if (ctl_i.sweep_wr) begin
      ram_addr  = sweep_q;
      ram_wdata = fill_q ? mfb_pkg::BYTE_ALL_ON : mfb_pkg::BYTE_ALL_OFF;
    end else if (ctl_i.pix_wr) begin
      ram_addr  = pix_addr_q;
      ram_wdata = pix_on_q ? (ram_rdata | pix_mask_q) : (ram_rdata & ~pix_mask_q);
    end else begin
      ram_addr  = ctl_i.rd_pix ? pix_addr : ref_addr;
      ram_wdata = ram_rdata;
    end
  end

  assign ram_we = ctl_i.sweep_wr || ctl_i.pix_wr;

  mfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.rd_en),
    .rdata_o (ram_rdata)
  );

  // Stream byte for the current slot
  logic [7:0] ref_byte;

  always_comb begin
    if (slot_q == SW'(0)) begin
      ref_byte = mfb_pkg::SEQ_START_LINE;
    end else if (slot_q == SW'(1)) begin
      ref_byte = mfb_pkg::SEQ_PAGE_BASE | 8'(page_q);
    end else if (slot_q == SW'(2)) begin
      ref_byte = mfb_pkg::SEQ_COL_HI;
    end else if (slot_q == SW'(3)) begin
      ref_byte = mfb_pkg::SEQ_COL_LO;
    end else begin
      ref_byte = ram_rdata;
    end
  end

  // Output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       is_data_q;
  logic       frame_last_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_byte_q   <= ref_byte;
      is_data_q    <= slot_data;
      frame_last_q <= slot_end && page_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_data_o    = is_data_q;
  assign frame_last_o = frame_last_q;

endmodule

// File: design/mfb_checker.sv
// Port-level assertions of the framebuffer and their bind to the top level.
module mfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] command_i,
  input logic [7:0] pos_x_i,
  input logic [7:0] pos_y_i,
  input logic       pixel_on_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_data_o,
  input logic       frame_last_o
);

  // A stalled input word stays offered with its fields unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable({command_i, pos_x_i, pos_y_i, pixel_on_i}))
    else $error("input word changed while stalled");

  // A stalled result word stays offered with its fields unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable({out_byte_o, is_data_o, frame_last_o}))
    else $error("result word dropped while stalled");

  // Frame end marker only on a data byte
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> is_data_o)
    else $error("frame end flagged on a command byte");

  // Command bytes come from the page header set only
  a_cmd_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_data_o |->
      (out_byte_o == mfb_pkg::SEQ_START_LINE) ||
      ((out_byte_o & 8'hF0) == mfb_pkg::SEQ_PAGE_BASE) ||
      (out_byte_o == mfb_pkg::SEQ_COL_HI) || (out_byte_o == mfb_pkg::SEQ_COL_LO))
    else $error("unexpected command byte in refresh stream");

endmodule

bind mono_lcd_page_framebuffer_unit mfb_checker u_mfb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .command_i    (command_i),
  .pos_x_i      (pos_x_i),
  .pos_y_i      (pos_y_i),
  .pixel_on_i   (pixel_on_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .is_data_o    (is_data_o),
  .frame_last_o (frame_last_o)
);

// File: tb/tb_mono_lcd_page_framebuffer_unit.sv
// Self-checking testbench for the page-organised monochrome panel framebuffer.
`timescale 1ns / 1ps

module tb_mono_lcd_page_framebuffer_unit;

  localparam int unsigned W          = 128;
  localparam int unsigned P          = 8;
  localparam int unsigned ROWS       = P * 8;
  localparam int unsigned PIX_BYTES  = W * P;
  localparam int unsigned PAGE_SLOTS = mfb_pkg::CMD_SLOTS + W;
  localparam int          WD_LIMIT   = 6000;  // > clearing pass, sweeps and the long hold-off
  localparam int          HOLD_LEN   = 400;
  localparam int          TAIL_LEN   = 32;
  localparam int          PHASE_LEN  = 160;
  localparam int          FINAL_LEN  = 35;

  // One input word and one refresh stream byte
  typedef struct {
    mfb_pkg::cmd_e cmd;
    logic [7:0]    x;
    logic [7:0]    y;
    logic          on;
  } word_t;

  typedef struct {
    logic [7:0] data;
    logic       dat;
    logic       last;
  } stream_byte_t;

  // Mirror of the buffer and the refresh position, plus the queue of bytes still due
  class fb_scoreboard;
    logic [7:0]   pix [PIX_BYTES];
    int unsigned  page;
    int unsigned  slot;
    stream_byte_t due_bytes[$];
    int           errors;

    function new();
      foreach (pix[k]) pix[k] = mfb_pkg::BYTE_ALL_OFF;
      page   = 0;
      slot   = 0;
      errors = 0;
    endfunction

    function int pending();
      return due_bytes.size();
    endfunction

    // Apply one accepted word; refresh words queue the byte they will produce
    function void note_word(word_t w);
      int unsigned  idx;
      stream_byte_t sb;
      case (w.cmd)
        mfb_pkg::CMD_SET_PIXEL: begin
          if (w.x < W && w.y < ROWS) begin
            idx = (w.y >> 3) * W + (W - 1 - w.x);
            if (w.on) pix[idx][w.y[2:0]] = 1'b1;
            else      pix[idx][w.y[2:0]] = 1'b0;
          end
        end
        mfb_pkg::CMD_CLEAR_ALL: foreach (pix[k]) pix[k] = mfb_pkg::BYTE_ALL_OFF;
        mfb_pkg::CMD_FILL_ALL:  foreach (pix[k]) pix[k] = mfb_pkg::BYTE_ALL_ON;
        default: begin
          sb.dat  = 1'b0;
          sb.last = 1'b0;
          case (slot)
            0:       sb.data = mfb_pkg::SEQ_START_LINE;
            1:       sb.data = mfb_pkg::SEQ_PAGE_BASE | {4'h0, page[3:0]};
            2:       sb.data = mfb_pkg::SEQ_COL_HI;
            3:       sb.data = mfb_pkg::SEQ_COL_LO;
            default: begin
              sb.data = pix[page * W + (slot - mfb_pkg::CMD_SLOTS)];
              sb.dat  = 1'b1;
              sb.last = (slot == PAGE_SLOTS - 1) && (page == P - 1);
            end
          endcase
          due_bytes.push_back(sb);
          slot++;
          if (slot >= PAGE_SLOTS) begin
            slot = 0;
            page = (page + 1 >= P) ? 0 : page + 1;
          end
        end
      endcase
    endfunction

    // Compare one output word against the oldest byte due
    function void check_byte(logic [7:0] data, logic dat, logic last);
      stream_byte_t sb;
      if (due_bytes.size() == 0) begin
        $error("output word 0x%02h with nothing due", data);
        errors++;
        return;
      end
      sb = due_bytes.pop_front();
      if (data !== sb.data) begin
        $error("out_byte: expected 0x%02h, got 0x%02h", sb.data, data);
        errors++;
      end
      if (dat !== sb.dat) begin
        $error("is_data: expected %0b, got %0b", sb.dat, dat);
        errors++;
      end
      if (last !== sb.last) begin
        $error("frame_last: expected %0b, got %0b", sb.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready_o;
  logic [1:0] command;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic       pixel_on;
  logic       out_valid_o;
  logic       out_ready;
  logic [7:0] out_byte_o;
  logic       is_data_o;
  logic       frame_last_o;

  fb_scoreboard sb = new();
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_reqs    = 0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  mono_lcd_page_framebuffer_unit #(
    .PANEL_WIDTH(W),
    .PANEL_PAGES(P)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .command_i   (command),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .pixel_on_i  (pixel_on),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte_o),
    .is_data_o   (is_data_o),
    .frame_last_o(frame_last_o)
  );

  // Handshake monitor and watchdog
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready) sb.check_byte(out_byte_o, is_data_o, frame_last_o);
      if (in_valid && in_ready_o) begin
        w.cmd = mfb_pkg::cmd_e'(command);
        w.x   = pos_x;
        w.y   = pos_y;
        w.on  = pixel_on;
        sb.note_word(w);
      end
      if ((out_valid_o && out_ready) || (in_valid && in_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WD_LIMIT);
        $display("tb_mono_lcd_page_framebuffer_unit: done, errors");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, with a long hold-off on request
  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != served) begin
        served    = hold_reqs;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  function automatic word_t mk(mfb_pkg::cmd_e c, logic [7:0] x, logic [7:0] y, logic on);
    word_t w;
    w.cmd = c;
    w.x   = x;
    w.y   = y;
    w.on  = on;
    return w;
  endfunction

  // Random word: refresh share given, rest mostly on-panel pixels
  function automatic word_t rand_word(int refresh_pct, bit with_sweeps);
    word_t w;
    int    r;
    w = mk(mfb_pkg::CMD_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom));
    r = $urandom_range(0, 99);
    if (r < refresh_pct) begin
      w.cmd = mfb_pkg::CMD_REFRESH;
    end else if (with_sweeps && r >= 96) begin
      w.cmd = (r >= 98) ? mfb_pkg::CMD_FILL_ALL : mfb_pkg::CMD_CLEAR_ALL;
    end else if (r < refresh_pct + 6) begin
      // off the panel in x, in y or both
      w.cmd = mfb_pkg::CMD_SET_PIXEL;
      if ($urandom_range(0, 1)) w.x = 8'($urandom_range(W, 255));
      else                      w.y = 8'($urandom_range(ROWS, 255));
    end else begin
      w.cmd = mfb_pkg::CMD_SET_PIXEL;
      w.x   = 8'($urandom_range(0, W - 1));
      w.y   = 8'($urandom_range(0, ROWS - 1));
    end
    return w;
  endfunction

  // Offer one word at the falling edge and hold it until taken
  task automatic send_word(word_t w);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    command  = w.cmd;
    pos_x    = w.x;
    pos_y    = w.y;
    pixel_on = w.on;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    int n;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    command  = mfb_pkg::CMD_SET_PIXEL;
    pos_x    = 8'h00;
    pos_y    = 8'h00;
    pixel_on = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: command bytes of page 0 with junk in the ignored fields
    send_word(mk(mfb_pkg::CMD_REFRESH, 8'hFF, 8'hFF, 1'b1));
    send_word(mk(mfb_pkg::CMD_REFRESH, 8'h00, 8'h00, 1'b0));
    send_word(mk(mfb_pkg::CMD_REFRESH, 8'hAA, 8'h55, 1'b1));
    send_word(mk(mfb_pkg::CMD_REFRESH, 8'h55, 8'hAA, 1'b0));
    // mirrored column: x 127 lands in column 0
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd127, 8'd7, 1'b1));
    send_word(mk(mfb_pkg::CMD_REFRESH, 8'h00, 8'h00, 1'b0));
    // set then clear the same bit, then a neighbor
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd126, 8'd0, 1'b1));
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd126, 8'd0, 1'b0));
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd126, 8'd1, 1'b1));
    send_word(mk(mfb_pkg::CMD_REFRESH, 8'h00, 8'h00, 1'b0));
    // off the panel: must leave column 2 dark
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd128, 8'd0, 1'b1));
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd255, 8'd255, 1'b1));
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd0, 8'd64, 1'b1));
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd125, 8'd64, 1'b1));
    send_word(mk(mfb_pkg::CMD_REFRESH, 8'h00, 8'h00, 1'b0));
    // fill, clear, corner pixels
    send_word(mk(mfb_pkg::CMD_FILL_ALL, 8'hFF, 8'hFF, 1'b0));
    send_word(mk(mfb_pkg::CMD_REFRESH, 8'h00, 8'h00, 1'b0));
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd0, 8'd63, 1'b0));
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd123, 8'd5, 1'b0));
    send_word(mk(mfb_pkg::CMD_REFRESH, 8'h00, 8'h00, 1'b1));
    send_word(mk(mfb_pkg::CMD_CLEAR_ALL, 8'h00, 8'h00, 1'b1));
    send_word(mk(mfb_pkg::CMD_SET_PIXEL, 8'd0, 8'd0, 1'b1));
    send_word(mk(mfb_pkg::CMD_REFRESH, 8'h00, 8'h00, 1'b0));

    // Phase 1: light sender idling, heavy receiver idling
    snd_idle_pct = 13;
    rcv_idle_pct = 72;
    // long receiver hold-off while refresh words keep coming
    hold_reqs++;
    for (n = 0; n < 12; n++) send_word(rand_word(100, 1'b0));
    // sender pauses until the output side has caught up
    wait_drained();
    for (n = 0; n < PHASE_LEN; n++) send_word(rand_word(55, 1'b1));

    // Phase 2: the other way round
    snd_idle_pct = 72;
    rcv_idle_pct = 13;
    for (n = 0; n < PHASE_LEN; n++) send_word(rand_word(55, 1'b1));

    // Phase 3: no idling, then a refresh-heavy tail
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (n = 0; n < PHASE_LEN; n++) send_word(rand_word(55, 1'b1));
    for (n = 0; n < FINAL_LEN; n++) send_word(rand_word(85, 1'b0));

    // Drain and let the block settle
    wait_drained();
    repeat (TAIL_LEN) @(negedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d output words never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_mono_lcd_page_framebuffer_unit: done, clean");
    end else begin
      $display("tb_mono_lcd_page_framebuffer_unit: done, errors");
    end
    $finish;
  end

endmodule
